/* sv/qte_pkg.sv */
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for quaternion_to_euler_angles
// Word widths, the CORDIC arctangent table and the output angle limits.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 14;

  localparam int QW  = 16;  // quaternion component width
  localparam int PW  = 32;  // product width
  localparam int CW  = 48;  // CORDIC x/y width
  localparam int ZW  = 34;  // angle accumulator width, Q4.30
  localparam int TW  = 32;  // asin argument width, Q.30
  localparam int SVW = 61;  // radicand width
  localparam int RTW = 31;  // root width
  localparam int SQ_STEPS = 31;

  localparam int ANG_TABLE_LEN = 24;
  localparam int ROLL_LIMIT    = 25736;
  localparam int PITCH_LIMIT   = 12868;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic signed [ZW-1:0] ATAN_Q30 [ANG_TABLE_LEN] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  typedef struct packed {
    logic signed [CW-1:0] ry;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] yy;
    logic signed [CW-1:0] yx;
  } atan_ops_t;

endpackage

/* sv/qte_prod.sv */
// ----------------------------------------------------------------------------
// qte_prod: quaternion products and atan2 / asin operands
// Three stages: products, sums with the asin argument, radicand 1 - t^2.
// ----------------------------------------------------------------------------
module qte_prod import qte_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic signed [QW-1:0]  qx,
  input  logic signed [QW-1:0]  qy,
  input  logic signed [QW-1:0]  qz,
  input  logic signed [QW-1:0]  qw,
  output logic                  out_vld,
  output atan_ops_t             ops,
  output logic signed [TW-1:0]  t_arg,
  output logic [SVW-1:0]        rad
);

  localparam int K  = 30 - 2 * FRAC_BITS;
  localparam int KP = (K >= 0) ? K : 0;
  localparam int KN = (K < 0) ? -K : 1;
  localparam logic signed [CW-1:0] ONE  = CW'(1) <<< (2 * FRAC_BITS);
  localparam logic signed [CW-1:0] HALF = CW'(1) <<< (KN - 1);
  localparam logic signed [CW-1:0] T_MAX = CW'(1) <<< 30;

  logic [2:0] vld_r;
  logic signed [PW-1:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wz_r, p_xy_r, p_zz_r, p_wy_r,
                        p_zx_r;
  atan_ops_t ops1_nxt, ops1_r, ops2_r;
  logic signed [TW-1:0] t_nxt, t1_r, t2_r;
  logic signed [CW-1:0] s_sum, s_clip, t_wide;
  logic signed [63:0] t_sq;
  logic [SVW-1:0] rad_nxt, rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r <= qw * qx;
      p_yz_r <= qy * qz;
      p_xx_r <= qx * qx;
      p_yy_r <= qy * qy;
      p_wz_r <= qw * qz;
      p_xy_r <= qx * qy;
      p_zz_r <= qz * qz;
      p_wy_r <= qw * qy;
      p_zx_r <= qz * qx;
    end
  end

  always_comb begin
    ops1_nxt.ry = (CW'(p_wx_r) + CW'(p_yz_r)) <<< 1;
    ops1_nxt.rx = ONE - ((CW'(p_xx_r) + CW'(p_yy_r)) <<< 1);
    ops1_nxt.yy = (CW'(p_wz_r) + CW'(p_xy_r)) <<< 1;
    ops1_nxt.yx = ONE - ((CW'(p_yy_r) + CW'(p_zz_r)) <<< 1);
    s_sum = (CW'(p_wy_r) - CW'(p_zx_r)) <<< 1;
    if (s_sum > ONE) begin
      s_clip = ONE;
    end else if (s_sum < -ONE) begin
      s_clip = -ONE;
    end else begin
      s_clip = s_sum;
    end
    if (K >= 0) begin
      t_wide = s_clip <<< KP;
    end else begin
      t_wide = (s_clip + HALF) >>> KN;
    end
    if (t_wide > T_MAX) begin
      t_nxt = TW'(T_MAX);
    end else if (t_wide < -T_MAX) begin
      t_nxt = TW'(-T_MAX);
    end else begin
      t_nxt = TW'(t_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops1_r <= ops1_nxt;
      t1_r   <= t_nxt;
    end
  end

  always_comb begin
    t_sq    = 64'(t1_r) * 64'(t1_r);
    rad_nxt = SVW'((64'sd1 <<< 60) - t_sq);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops2_r <= ops1_r;
      t2_r   <= t1_r;
      rad_r  <= rad_nxt;
    end
  end

  assign out_vld = vld_r[2];
  assign ops     = ops2_r;
  assign t_arg   = t2_r;
  assign rad     = rad_r;

endmodule

/* sv/qte_isqrt.sv */
// ----------------------------------------------------------------------------
// qte_isqrt: pipelined integer square root
// One result bit per stage; the atan2 operands ride along.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  atan_ops_t             in_ops,
  input  logic signed [TW-1:0]  in_t,
  input  logic [SVW-1:0]        in_rad,
  output logic                  out_vld,
  output atan_ops_t             out_ops,
  output logic signed [TW-1:0]  out_t,
  output logic [RTW-1:0]        out_root
);

  logic                 vld_r [SQ_STEPS];
  logic [SVW-1:0]       v_r   [SQ_STEPS];
  logic [SVW-1:0]       res_r [SQ_STEPS];
  atan_ops_t            ops_r [SQ_STEPS];
  logic signed [TW-1:0] t_r   [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    localparam logic [SVW-1:0] BIT = SVW'(1) << (2 * (SQ_STEPS - 1 - j));
    logic                 vld_i;
    logic [SVW-1:0]       v_i, res_i, trial;
    atan_ops_t            ops_i;
    logic signed [TW-1:0] t_i;

    if (j == 0) begin : g_first
      assign vld_i = in_vld;
      assign v_i   = in_rad;
      assign res_i = '0;
      assign ops_i = in_ops;
      assign t_i   = in_t;
    end else begin : g_next
      assign vld_i = vld_r[j-1];
      assign v_i   = v_r[j-1];
      assign res_i = res_r[j-1];
      assign ops_i = ops_r[j-1];
      assign t_i   = t_r[j-1];
    end

    assign trial = res_i + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ops_r[j] <= ops_i;
        t_r[j]   <= t_i;
        if (v_i >= trial) begin
          v_r[j]   <= v_i - trial;
          res_r[j] <= (res_i >> 1) + BIT;
        end else begin
          v_r[j]   <= v_i;
          res_r[j] <= res_i >> 1;
        end
      end
    end
  end

  assign out_vld  = vld_r[SQ_STEPS-1];
  assign out_ops  = ops_r[SQ_STEPS-1];
  assign out_t    = t_r[SQ_STEPS-1];
  assign out_root = res_r[SQ_STEPS-1][RTW-1:0];

endmodule

/* sv/qte_cordic.sv */
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring CORDIC atan2
// Quadrant fold stage, one stage per micro-rotation, then rounding to Q3.13.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int LIMIT         = ROLL_LIMIT,
  parameter int OW            = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic signed [CW-1:0]  in_y,
  input  logic signed [CW-1:0]  in_x,
  output logic                  out_vld,
  output logic signed [OW-1:0]  angle
);

  localparam logic signed [ZW-1:0] RND = ZW'(1) <<< 16;
  localparam logic signed [16:0] LIM = 17'(LIMIT);

  logic                 vld0_r, zero0_r;
  logic signed [CW-1:0] x0_nxt, y0_nxt, x0_r, y0_r;
  logic signed [ZW-1:0] z0_nxt, z0_r;

  logic                 vld_r  [CORDIC_STAGES];
  logic                 zero_r [CORDIC_STAGES];
  logic signed [CW-1:0] x_r    [CORDIC_STAGES];
  logic signed [CW-1:0] y_r    [CORDIC_STAGES];
  logic signed [ZW-1:0] z_r    [CORDIC_STAGES];

  logic signed [ZW-1:0] z_end, z_rnd;
  logic signed [16:0]   a_rnd;

  always_comb begin
    x0_nxt = in_x;
    y0_nxt = in_y;
    z0_nxt = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0_nxt = in_y;
        y0_nxt = -in_x;
        z0_nxt = HALF_PI_Q30;
      end else begin
        x0_nxt = -in_y;
        y0_nxt = in_x;
        z0_nxt = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r    <= x0_nxt;
      y0_r    <= y0_nxt;
      z0_r    <= z0_nxt;
      zero0_r <= (in_x == 0) && (in_y == 0);
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    logic                 vld_i, zero_i;
    logic signed [CW-1:0] x_i, y_i, xs, ys;
    logic signed [ZW-1:0] z_i;

    if (i == 0) begin : g_first
      assign vld_i  = vld0_r;
      assign zero_i = zero0_r;
      assign x_i    = x0_r;
      assign y_i    = y0_r;
      assign z_i    = z0_r;
    end else begin : g_next
      assign vld_i  = vld_r[i-1];
      assign zero_i = zero_r[i-1];
      assign x_i    = x_r[i-1];
      assign y_i    = y_r[i-1];
      assign z_i    = z_r[i-1];
    end

    assign xs = x_i >>> i;
    assign ys = y_i >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i] <= zero_i;
        if (y_i >= 0) begin
          x_r[i] <= x_i + ys;
          y_r[i] <= y_i - xs;
          z_r[i] <= z_i + ATAN_Q30[i];
        end else begin
          x_r[i] <= x_i - ys;
          y_r[i] <= y_i + xs;
          z_r[i] <= z_i - ATAN_Q30[i];
        end
      end
    end
  end

  always_comb begin
    z_end = zero_r[CORDIC_STAGES-1] ? '0 : z_r[CORDIC_STAGES-1];
    z_rnd = (z_end + RND) >>> 17;
    a_rnd = z_rnd[16:0];
    if (a_rnd > LIM) begin
      a_rnd = LIM;
    end else if (a_rnd < -LIM) begin
      a_rnd = -LIM;
    end
  end

  assign out_vld = vld_r[CORDIC_STAGES-1];
  assign angle   = OW'(a_rnd);

endmodule

/* sv/quaternion_to_euler_angles.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: quaternion to roll, pitch and yaw
// Fully pipelined conversion of Q2.14 quaternions to Q3.13 Euler angles (pitch Q2.13).
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one quaternion per transfer, x in the lowest bits.
//   The out_ channel returns roll, pitch and yaw for each quaternion, in order.
//   From input transfer to out_tvalid a quaternion passes through 3 product
//   stages, 31 square root stages, 1 quadrant stage, CORDIC_STAGES rotation
//   stages (16 by default) and the output register. The three atan2 units run
//   side by side.
//   Throughput is one quaternion per cycle while out_tready is high.
//   When the output register holds a result and out_tready is low, the whole
//   pipeline halts and in_tready drops in the same cycle; nothing is lost.
//   Reset clears every valid bit, so the pipeline starts empty.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // roll_angle, pitch_angle, yaw_angle, zero pad
);

  logic en;
  logic p_vld, s_vld, r_vld, pi_vld, y_vld;
  atan_ops_t p_ops, s_ops;
  logic signed [TW-1:0] p_t, s_t;
  logic [SVW-1:0] p_rad;
  logic [RTW-1:0] s_root;
  logic signed [15:0] roll_a, yaw_a;
  logic signed [14:0] pitch_a;

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  qte_prod #(.FRAC_BITS(FRAC_BITS)) u_prod (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_tvalid),
    .qx(in_tdata[15:0]), .qy(in_tdata[31:16]),
    .qz(in_tdata[47:32]), .qw(in_tdata[63:48]),
    .out_vld(p_vld), .ops(p_ops), .t_arg(p_t), .rad(p_rad)
  );

  qte_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(p_vld), .in_ops(p_ops), .in_t(p_t), .in_rad(p_rad),
    .out_vld(s_vld), .out_ops(s_ops), .out_t(s_t), .out_root(s_root)
  );

  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .LIMIT(ROLL_LIMIT), .OW(16)) u_roll (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s_vld),
    .in_y(s_ops.ry), .in_x(s_ops.rx),
    .out_vld(r_vld), .angle(roll_a)
  );

  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .LIMIT(PITCH_LIMIT), .OW(15)) u_pitch (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s_vld),
    .in_y(CW'(s_t)), .in_x(CW'({1'b0, s_root})),
    .out_vld(pi_vld), .angle(pitch_a)
  );

  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .LIMIT(ROLL_LIMIT), .OW(16)) u_yaw (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s_vld),
    .in_y(s_ops.yy), .in_x(s_ops.yx),
    .out_vld(y_vld), .angle(yaw_a)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= r_vld && pi_vld && y_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {1'b0, yaw_a, pitch_a, roll_a};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTH
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (r_vld == pi_vld) && (pi_vld == y_vld))
    else $error("atan2 lanes out of step");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[30:16]) <= 15'sd12868) &&
                   ($signed(out_tdata[30:16]) >= -15'sd12868))
    else $error("pitch out of range");
`endif

endmodule
